// File: rtl/i2cbc_pkg.sv
`default_nettype none

package i2cbc_pkg;

  // Register widths.
  localparam int unsigned PulseTicksW   = 8;
  localparam int unsigned TimeoutTicksW = 10;
  localparam int unsigned MaxPulsesW    = 4;
  localparam int unsigned CfgDataW      = 10;
  localparam int unsigned CfgIndexW     = 2;
  localparam int unsigned TimerW        = 10;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_PULSE_TICKS   = 2'd0,
    CFG_TIMEOUT_TICKS = 2'd1,
    CFG_MAX_PULSES    = 2'd2
  } cfg_index_e;

  // Register values after reset.
  localparam logic [PulseTicksW-1:0]   PulseTicksRst   = 8'd5;
  localparam logic [TimeoutTicksW-1:0] TimeoutTicksRst = 10'd100;
  localparam logic [MaxPulsesW-1:0]    MaxPulsesRst    = 4'd9;

  // Sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_SETTLE     = 4'd1,
    PH_WAIT_FIRST = 4'd2,
    PH_CHECK      = 4'd3,
    PH_SCL_LOW    = 4'd4,
    PH_PULSE_WAIT = 4'd5,
    PH_PULSE_GAP  = 4'd6,
    PH_SDA_HOLD   = 4'd7,
    PH_STOP_WAIT  = 4'd8,
    PH_STOP_GAP   = 4'd9,
    PH_FINAL_GAP  = 4'd10
  } phase_e;

endpackage

`default_nettype wire

// File: rtl/i2c_bus_clear_sequencer.sv
`default_nettype none

// I2C bus clear sequencer. Every input beat is one microsecond tick carrying
// the sampled SCL and SDA levels and an optional start command; every input
// beat produces exactly one result beat showing the line drives, busy, done
// and success as they stand after that tick. The sequencer state advances
// only on an accepted input beat, so the tick rate is whatever rate the
// source offers beats at. The next state is worked out combinationally
// from the phase register, the tick timer and the pulse counter, and the
// result is held in a single output register. A new beat is taken in every
// cycle for as long as the sink keeps taking results (input ready is low
// only while a result is waiting and the sink is stalled). A start is
// honoured only from idle. Configuration writes are taken at once on the
// write port and should only be made while the block is idle.
module i2c_bus_clear_sequencer
  import i2cbc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,

  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 command_i,
  input  wire logic                 scl_level_i,
  input  wire logic                 sda_level_i,

  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      scl_drive_low_o,
  output logic                      sda_drive_low_o,
  output logic                      busy_res_o,
  output logic                      done_res_o,
  output logic                      success_o
);

  // Configuration registers.
  logic [PulseTicksW-1:0]   pulse_ticks_q;
  logic [TimeoutTicksW-1:0] timeout_ticks_q;
  logic [MaxPulsesW-1:0]    max_pulses_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ticks_q   <= PulseTicksRst;
      timeout_ticks_q <= TimeoutTicksRst;
      max_pulses_q    <= MaxPulsesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PULSE_TICKS:   pulse_ticks_q   <= cfg_data_i[PulseTicksW-1:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i[TimeoutTicksW-1:0];
        CFG_MAX_PULSES:    max_pulses_q    <= cfg_data_i[MaxPulsesW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the output register frees up in the same cycle it is taken.
  logic in_accept;
  logic out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // Sequencer state.
  phase_e                  phase_q, phase_d;
  logic [TimerW-1:0]       tick_timer_q, tick_timer_d;
  logic [MaxPulsesW-1:0]   pulse_count_q, pulse_count_d;

  logic [TimerW:0] timer_inc;
  logic            pulse_hit;
  logic            timeout_hit;
  logic            done;
  logic            ok;

  // The timer counts one tick per beat; a timed phase ends on the tick where
  // the incremented count reaches its limit. A zero limit ends it at once.
  assign timer_inc   = {1'b0, tick_timer_q} + {{TimerW{1'b0}}, 1'b1};
  assign pulse_hit   = timer_inc >= {{(TimerW + 1 - PulseTicksW){1'b0}}, pulse_ticks_q};
  assign timeout_hit = timer_inc >= {{(TimerW + 1 - TimeoutTicksW){1'b0}}, timeout_ticks_q};

  always_comb begin
    phase_d       = phase_q;
    tick_timer_d  = tick_timer_q;
    pulse_count_d = pulse_count_q;
    done          = 1'b0;
    ok            = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        if (command_i) begin
          pulse_count_d = '0;
          phase_d       = PH_SETTLE;
          tick_timer_d  = '0;
        end
      end
      PH_SETTLE: begin
        if (pulse_hit) begin
          phase_d      = PH_WAIT_FIRST;
          tick_timer_d = '0;
        end else begin
          tick_timer_d = timer_inc[TimerW-1:0];
        end
      end
      PH_WAIT_FIRST: begin
        if (scl_level_i) begin
          phase_d      = PH_CHECK;
          tick_timer_d = '0;
        end else if (timeout_hit) begin
          // SCL never came free: give up straight away.
          done = 1'b1;
        end else begin
          tick_timer_d = timer_inc[TimerW-1:0];
        end
      end
      PH_CHECK: begin
        // Keep clocking only while SDA is still held low by a target and the pulse limit is not reached.
        tick_timer_d = '0;
        if (sda_level_i || (pulse_count_q >= max_pulses_q)) begin
          phase_d = PH_SDA_HOLD;
        end else begin
          phase_d = PH_SCL_LOW;
        end
      end
      PH_SCL_LOW: begin
        if (pulse_hit) begin
          phase_d      = PH_PULSE_WAIT;
          tick_timer_d = '0;
        end else begin
          tick_timer_d = timer_inc[TimerW-1:0];
        end
      end
      PH_PULSE_WAIT: begin
        if (scl_level_i) begin
          phase_d      = PH_PULSE_GAP;
          tick_timer_d = '0;
        end else if (timeout_hit) begin
          // SCL is being stretched for too long: stop pulsing and go on.
          phase_d      = PH_SDA_HOLD;
          tick_timer_d = '0;
        end else begin
          tick_timer_d = timer_inc[TimerW-1:0];
        end
      end
      PH_PULSE_GAP: begin
        if (pulse_hit) begin
          pulse_count_d = pulse_count_q + {{(MaxPulsesW-1){1'b0}}, 1'b1};
          phase_d       = PH_CHECK;
          tick_timer_d  = '0;
        end else begin
          tick_timer_d = timer_inc[TimerW-1:0];
        end
      end
      PH_SDA_HOLD: begin
        if (pulse_hit) begin
          phase_d      = PH_STOP_WAIT;
          tick_timer_d = '0;
        end else begin
          tick_timer_d = timer_inc[TimerW-1:0];
        end
      end
      PH_STOP_WAIT: begin
        if (scl_level_i) begin
          phase_d      = PH_STOP_GAP;
          tick_timer_d = '0;
        end else if (timeout_hit) begin
          done = 1'b1;
        end else begin
          tick_timer_d = timer_inc[TimerW-1:0];
        end
      end
      PH_STOP_GAP: begin
        if (pulse_hit) begin
          phase_d      = PH_FINAL_GAP;
          tick_timer_d = '0;
        end else begin
          tick_timer_d = timer_inc[TimerW-1:0];
        end
      end
      PH_FINAL_GAP: begin
        if (pulse_hit) begin
          done = 1'b1;
          ok   = scl_level_i && sda_level_i;
        end else begin
          tick_timer_d = timer_inc[TimerW-1:0];
        end
      end
      default: begin
        phase_d      = PH_IDLE;
        tick_timer_d = '0;
      end
    endcase

    if (done) begin
      phase_d      = PH_IDLE;
      tick_timer_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      tick_timer_q  <= '0;
      pulse_count_q <= '0;
    end else if (in_accept) begin
      phase_q       <= phase_d;
      tick_timer_q  <= tick_timer_d;
      pulse_count_q <= pulse_count_d;
    end
  end

  // Result register. The drives follow the phase entered on this tick.
  logic scl_drive_low_q, sda_drive_low_q, busy_res_q, done_res_q, success_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      scl_drive_low_q <= (phase_d == PH_SCL_LOW);
      sda_drive_low_q <= (phase_d == PH_SDA_HOLD) || (phase_d == PH_STOP_WAIT) ||
                         (phase_d == PH_STOP_GAP);
      busy_res_q      <= (phase_d != PH_IDLE);
      done_res_q      <= done;
      success_q       <= ok;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scl_drive_low_o = scl_drive_low_q;
  assign sda_drive_low_o = sda_drive_low_q;
  assign busy_res_o      = busy_res_q;
  assign done_res_o      = done_res_q;
  assign success_o       = success_q;

  // The two lines are never pulled low together.
  a_drive_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(scl_drive_low_o && sda_drive_low_o))
    else $error("SCL and SDA driven low together");

  // A finished sequence is no longer busy, and success comes only with done.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (done_res_o || success_o)) |-> (done_res_o && !busy_res_o))
    else $error("done or success reported with sequencer still busy");

  // A plain tick in idle leaves the sequencer idle with nothing driven.
  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (phase_q == PH_IDLE) && !command_i) |=>
      (!busy_res_o && !done_res_o && !scl_drive_low_o && !sda_drive_low_o))
    else $error("idle tick left the sequencer active");

  // A start from idle always leaves the sequencer busy.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (phase_q == PH_IDLE) && command_i) |=> (busy_res_o && out_valid_o))
    else $error("start from idle did not begin a sequence");

  // The state moves only on an accepted beat.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> ($stable(phase_q) && $stable(tick_timer_q) && $stable(pulse_count_q)))
    else $error("sequencer state moved without an input beat");

endmodule

`default_nettype wire
